// ----- sv/hlsd_pkg.sv -----
// ----------------------------------------------------------------------------
// hlsd_pkg
// Shared types, constants and tables of the hand landmark shape descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

package hlsd_pkg;

  localparam int LANDMARKS    = 21;
  localparam int LM_AW        = $clog2(LANDMARKS);
  localparam int COORD_W      = 16;
  localparam int FEATURES     = 20;
  localparam int FEAT_W       = 16;
  localparam int FIDX_W       = 5;
  localparam int FINGERS      = 5;
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 46;
  localparam int ITER_W       = 6;

  // feature index bases
  localparam int STR_BASE = 10;
  localparam int TIP_BASE = 15;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      first_point;
  } in_beat_t;

  typedef struct packed {
    logic [FEAT_W-1:0] feature_value;
    logic [FIDX_W-1:0] feature_index;
    logic              last_feature;
  } out_beat_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_VEC_LOAD,
    OP_VEC_SHIFT,
    OP_CORDIC,
    OP_Z_SAVE,
    OP_ANG_WRITE,
    OP_STR_INIT,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_ADD,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_HYP_END,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_STR_WRITE,
    OP_TIP_SAT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_ANG_CHK,
    S_VEC_LOAD,
    S_VEC_NORM,
    S_CORDIC,
    S_Z_SAVE,
    S_ANG_WRITE,
    S_STR_INIT,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_ADD,
    S_SQRT_INIT,
    S_SQRT,
    S_HYP_END,
    S_STR_CHK,
    S_DIV_INIT,
    S_DIV,
    S_STR_WRITE,
    S_TIP_CHK,
    S_TIP_SAT,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic              wr;
    logic [LM_AW-1:0]  waddr;
    logic [LM_AW-1:0]  raddr;
    logic              cap;
    logic [1:0]        slot;
    logic              tsel;
    logic              vsel;
    logic [1:0]        seg;
    logic              tip;
    logic [3:0]        iter;
    logic [FIDX_W-1:0] fidx;
    logic [FIDX_W-1:0] eidx;
  } cmd_t;

  typedef struct packed {
    logic norm_ok;
    logic ang_zero;
    logic path_zero;
    logic tip_big;
  } status_t;

  // arctangent of 2^-i in binary angle units, 2^32 per turn
  function automatic logic [31:0] atan_lut(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0:    r = 32'h2000_0000;
      4'd1:    r = 32'h12E4_051E;
      4'd2:    r = 32'h09FB_385B;
      4'd3:    r = 32'h0511_11D4;
      4'd4:    r = 32'h028B_0D43;
      4'd5:    r = 32'h0145_D7E1;
      4'd6:    r = 32'h00A2_F61E;
      4'd7:    r = 32'h0051_7C55;
      4'd8:    r = 32'h0028_BE53;
      4'd9:    r = 32'h0014_5F2F;
      4'd10:   r = 32'h000A_2F98;
      4'd11:   r = 32'h0005_17CC;
      4'd12:   r = 32'h0002_8BE6;
      4'd13:   r = 32'h0001_45F3;
      4'd14:   r = 32'h0000_A2FA;
      4'd15:   r = 32'h0000_517D;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // knuckle landmarks that join the wrist in the palm center
  function automatic logic is_knuckle(input logic [LM_AW-1:0] idx);
    return idx inside {LM_AW'(5), LM_AW'(9), LM_AW'(13), LM_AW'(17)};
  endfunction

endpackage

`default_nettype wire

// ----- sv/hlsd_ram.sv -----
// ----------------------------------------------------------------------------
// hlsd_ram
// Generic memory, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 21
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/hlsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// hlsd_ctrl
// Sequencer: point counting, feature computation steps and feature emission.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsd_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic                     first_point,
  output logic                          in_stall,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  input  wire hlsd_pkg::status_t        stat,
  output hlsd_pkg::cmd_t                cmd
);

  localparam int AW = hlsd_pkg::LM_AW;
  localparam int IW = hlsd_pkg::ITER_W;
  localparam int FW = hlsd_pkg::FIDX_W;

  hlsd_pkg::state_t state, state_next;
  logic [AW-1:0] pc, pc_next;
  logic [2:0]    finger, finger_next;
  logic          tsel, tsel_next;
  logic          vsel, vsel_next;
  logic [1:0]    seg, seg_next;
  logic          tipm, tipm_next;
  logic [IW-1:0] iter, iter_next;
  logic [FW-1:0] eidx, eidx_next;

  logic          in_fire;
  logic [AW-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= hlsd_pkg::S_IDLE;
      pc     <= '0;
      finger <= '0;
      tsel   <= 1'b0;
      vsel   <= 1'b0;
      seg    <= '0;
      tipm   <= 1'b0;
      iter   <= '0;
      eidx   <= '0;
    end else begin
      state  <= state_next;
      pc     <= pc_next;
      finger <= finger_next;
      tsel   <= tsel_next;
      vsel   <= vsel_next;
      seg    <= seg_next;
      tipm   <= tipm_next;
      iter   <= iter_next;
      eidx   <= eidx_next;
    end
  end

  // the hand-closing point waits until the previous hand is fully sent
  assign in_stall  = !((state == hlsd_pkg::S_IDLE) ||
                       ((state == hlsd_pkg::S_EMIT) &&
                        (pc != AW'(hlsd_pkg::LANDMARKS - 1))));
  assign out_valid = (state == hlsd_pkg::S_EMIT);
  assign in_fire   = in_valid && !in_stall;
  assign idx       = first_point ? '0 : pc;

  always_comb begin
    state_next  = state;
    pc_next     = pc;
    finger_next = finger;
    tsel_next   = tsel;
    vsel_next   = vsel;
    seg_next    = seg;
    tipm_next   = tipm;
    iter_next   = iter;
    eidx_next   = eidx;

    cmd       = '0;
    cmd.op    = hlsd_pkg::OP_NOP;
    cmd.wr    = in_fire;
    cmd.waddr = idx;
    cmd.raddr = AW'(1) + AW'({finger, 2'b00}) + AW'(iter[1:0]);
    cmd.slot  = 2'(iter - IW'(1));
    cmd.tsel  = tsel;
    cmd.vsel  = vsel;
    cmd.seg   = seg;
    cmd.tip   = tipm;
    cmd.iter  = iter[3:0];
    cmd.eidx  = eidx;
    cmd.fidx  = FW'({finger, tsel});

    case (state)
      hlsd_pkg::S_IDLE: begin
      end
      hlsd_pkg::S_LOAD: begin
        cmd.cap = (iter != '0);
        if (iter == IW'(4)) begin
          state_next = hlsd_pkg::S_ANG_CHK;
          tsel_next  = 1'b0;
        end else begin
          iter_next = iter + IW'(1);
        end
      end
      hlsd_pkg::S_ANG_CHK: begin
        if (stat.ang_zero) begin
          state_next = hlsd_pkg::S_ANG_WRITE;
        end else begin
          state_next = hlsd_pkg::S_VEC_LOAD;
          vsel_next  = 1'b0;
        end
      end
      hlsd_pkg::S_VEC_LOAD: begin
        cmd.op     = hlsd_pkg::OP_VEC_LOAD;
        state_next = hlsd_pkg::S_VEC_NORM;
      end
      hlsd_pkg::S_VEC_NORM: begin
        cmd.op = hlsd_pkg::OP_VEC_SHIFT;
        if (stat.norm_ok) begin
          state_next = hlsd_pkg::S_CORDIC;
          iter_next  = '0;
        end
      end
      hlsd_pkg::S_CORDIC: begin
        cmd.op = hlsd_pkg::OP_CORDIC;
        if (iter == IW'(hlsd_pkg::CORDIC_STEPS - 1)) begin
          state_next = vsel ? hlsd_pkg::S_ANG_WRITE : hlsd_pkg::S_Z_SAVE;
        end else begin
          iter_next = iter + IW'(1);
        end
      end
      hlsd_pkg::S_Z_SAVE: begin
        cmd.op     = hlsd_pkg::OP_Z_SAVE;
        vsel_next  = 1'b1;
        state_next = hlsd_pkg::S_VEC_LOAD;
      end
      hlsd_pkg::S_ANG_WRITE: begin
        cmd.op = hlsd_pkg::OP_ANG_WRITE;
        if (!tsel) begin
          tsel_next  = 1'b1;
          state_next = hlsd_pkg::S_ANG_CHK;
        end else begin
          state_next = hlsd_pkg::S_STR_INIT;
        end
      end
      hlsd_pkg::S_STR_INIT: begin
        cmd.op     = hlsd_pkg::OP_STR_INIT;
        seg_next   = '0;
        tipm_next  = 1'b0;
        state_next = hlsd_pkg::S_SQ_X;
      end
      hlsd_pkg::S_SQ_X: begin
        cmd.op     = hlsd_pkg::OP_SQ_X;
        state_next = hlsd_pkg::S_SQ_Y;
      end
      hlsd_pkg::S_SQ_Y: begin
        cmd.op     = hlsd_pkg::OP_SQ_Y;
        state_next = hlsd_pkg::S_SQ_ADD;
      end
      hlsd_pkg::S_SQ_ADD: begin
        cmd.op     = hlsd_pkg::OP_SQ_ADD;
        state_next = tipm ? hlsd_pkg::S_DIV_INIT : hlsd_pkg::S_SQRT_INIT;
      end
      hlsd_pkg::S_SQRT_INIT: begin
        cmd.op     = hlsd_pkg::OP_SQRT_INIT;
        iter_next  = '0;
        state_next = hlsd_pkg::S_SQRT;
      end
      hlsd_pkg::S_SQRT: begin
        cmd.op = hlsd_pkg::OP_SQRT_STEP;
        if (iter == IW'(hlsd_pkg::SQRT_STEPS - 1)) begin
          state_next = hlsd_pkg::S_HYP_END;
        end else begin
          iter_next = iter + IW'(1);
        end
      end
      hlsd_pkg::S_HYP_END: begin
        cmd.op   = hlsd_pkg::OP_HYP_END;
        cmd.fidx = FW'(hlsd_pkg::TIP_BASE) + FW'(finger);
        if (tipm) begin
          if (finger == 3'(hlsd_pkg::FINGERS - 1)) begin
            state_next = hlsd_pkg::S_EMIT;
            eidx_next  = '0;
          end else begin
            finger_next = finger + 3'd1;
            iter_next   = '0;
            state_next  = hlsd_pkg::S_LOAD;
          end
        end else if (seg == 2'd3) begin
          state_next = hlsd_pkg::S_STR_CHK;
        end else begin
          seg_next   = seg + 2'd1;
          state_next = hlsd_pkg::S_SQ_X;
        end
      end
      hlsd_pkg::S_STR_CHK: begin
        state_next = stat.path_zero ? hlsd_pkg::S_STR_WRITE : hlsd_pkg::S_DIV_INIT;
      end
      hlsd_pkg::S_DIV_INIT: begin
        cmd.op     = hlsd_pkg::OP_DIV_INIT;
        iter_next  = '0;
        state_next = hlsd_pkg::S_DIV;
      end
      hlsd_pkg::S_DIV: begin
        cmd.op = hlsd_pkg::OP_DIV_STEP;
        if (iter == IW'(hlsd_pkg::DIV_STEPS - 1)) begin
          state_next = tipm ? hlsd_pkg::S_SQRT_INIT : hlsd_pkg::S_STR_WRITE;
        end else begin
          iter_next = iter + IW'(1);
        end
      end
      hlsd_pkg::S_STR_WRITE: begin
        cmd.op     = hlsd_pkg::OP_STR_WRITE;
        cmd.fidx   = FW'(hlsd_pkg::STR_BASE) + FW'(finger);
        state_next = hlsd_pkg::S_TIP_CHK;
      end
      hlsd_pkg::S_TIP_CHK: begin
        tipm_next  = 1'b1;
        state_next = stat.tip_big ? hlsd_pkg::S_TIP_SAT : hlsd_pkg::S_SQ_X;
      end
      hlsd_pkg::S_TIP_SAT: begin
        cmd.op   = hlsd_pkg::OP_TIP_SAT;
        cmd.fidx = FW'(hlsd_pkg::TIP_BASE) + FW'(finger);
        if (finger == 3'(hlsd_pkg::FINGERS - 1)) begin
          state_next = hlsd_pkg::S_EMIT;
          eidx_next  = '0;
        end else begin
          finger_next = finger + 3'd1;
          iter_next   = '0;
          state_next  = hlsd_pkg::S_LOAD;
        end
      end
      hlsd_pkg::S_EMIT: begin
        if (!out_stall) begin
          if (eidx == FW'(hlsd_pkg::FEATURES - 1)) begin
            state_next = hlsd_pkg::S_IDLE;
          end else begin
            eidx_next = eidx + FW'(1);
          end
        end
      end
      default: begin
        state_next = hlsd_pkg::S_IDLE;
      end
    endcase

    if (in_fire) begin
      if (idx == AW'(hlsd_pkg::LANDMARKS - 1)) begin
        pc_next     = '0;
        finger_next = '0;
        iter_next   = '0;
        state_next  = hlsd_pkg::S_LOAD;
      end else begin
        pc_next = idx + AW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/hlsd_dp.sv -----
// ----------------------------------------------------------------------------
// hlsd_dp
// Datapath: landmark memory, point buffer, CORDIC, squarer, square root,
// divider and feature buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsd_dp (
  input  wire logic                           clk,
  input  wire hlsd_pkg::in_beat_t             in_beat,
  input  wire hlsd_pkg::cmd_t                 cmd,
  output hlsd_pkg::status_t                   stat,
  output logic [hlsd_pkg::FEAT_W-1:0]         feat_value
);

  localparam int CW  = hlsd_pkg::COORD_W;
  localparam int DW  = CW + 1;   // point difference
  localparam int SW  = CW + 3;   // sum of five points
  localparam int EW  = CW + 4;   // five times a tip less the sum
  localparam int XW  = 45;       // cordic vector
  localparam int MW  = 30;       // squarer operand
  localparam int PW  = 34;       // path length
  localparam int NW  = hlsd_pkg::DIV_STEPS;
  localparam int DNW = 34;       // divisor
  localparam int FTW = hlsd_pkg::FEAT_W;
  localparam logic [63:0] TIP_LIM = 64'(5 * 65536);

  // landmark memory
  logic [2*CW-1:0] rdata;

  hlsd_ram #(
    .WIDTH (2 * CW),
    .DEPTH (hlsd_pkg::LANDMARKS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (cmd.waddr),
    .wdata ({in_beat.point_x, in_beat.point_y}),
    .raddr (cmd.raddr),
    .rdata (rdata)
  );

  logic signed [CW-1:0]  px [4];
  logic signed [CW-1:0]  py [4];
  logic signed [SW-1:0]  sum_x, sum_y;
  logic signed [XW-1:0]  cx, cy;
  logic [31:0]           cz, z1;
  logic [1:0]            shamt;
  logic [2*MW-1:0]       prod;
  logic [63:0]           sacc;
  logic [63:0]           rad;
  logic [31:0]           root;
  logic [33:0]           srem;
  logic [PW-1:0]         path;
  logic [31:0]           direct;
  logic [NW-1:0]         dnum;
  logic [DNW-1:0]        dden;
  logic [DNW-1:0]        drem;
  logic [FTW-1:0]        feat [hlsd_pkg::FEATURES];

  // angle vectors
  logic [1:0]            i0, i1, i2, ia;
  logic signed [DW-1:0]  vx, vy;
  logic                  ang_zero;
  logic signed [XW-1:0]  ay_abs, xs, ys;
  logic [31:0]           dang, dfold;
  logic [32:0]           arnd;

  // finger segments
  logic [DW-1:0]         mx4 [4];
  logic [DW-1:0]         my4 [4];
  logic [DW-1:0]         orv;
  logic [63:0]           orw;
  logic [1:0]            sh_calc;
  logic [63:0]           segx, segy;
  logic signed [EW-1:0]  tdx, tdy;
  logic [EW-1:0]         tex, tey;
  logic [63:0]           texw, teyw;
  logic [MW-1:0]         opx, opy, opa;

  // iterative units
  logic [35:0]           sr2, trial;
  logic [32:0]           hyp;
  logic [DNW:0]          dr2;

  always_comb begin
    i0 = {1'b0, cmd.tsel};
    i1 = i0 + 2'd1;
    i2 = i0 + 2'd2;
    ia = cmd.vsel ? i2 : i0;
    vx = DW'(px[ia]) - DW'(px[i1]);
    vy = DW'(py[ia]) - DW'(py[i1]);
    ang_zero = ((px[i0] == px[i1]) && (py[i0] == py[i1])) ||
               ((px[i2] == px[i1]) && (py[i2] == py[i1]));

    ay_abs = cy[XW-1] ? -cy : cy;
    xs     = cx >>> cmd.iter;
    ys     = cy >>> cmd.iter;

    dang  = z1 - cz;
    dfold = (dang > 32'h8000_0000) ? -dang : dang;
    arnd  = (33'(dfold) + 33'(1 << 18)) >> 19;

    orv = '0;
    for (int k = 0; k < 4; k++) begin
      logic [1:0] a, b;
      logic signed [DW-1:0] dx, dy;
      a = (k == 3) ? 2'd3 : 2'(k + 1);
      b = (k == 3) ? 2'd0 : 2'(k);
      dx = DW'(px[a]) - DW'(px[b]);
      dy = DW'(py[a]) - DW'(py[b]);
      mx4[k] = dx[DW-1] ? DW'(-dx) : DW'(dx);
      my4[k] = dy[DW-1] ? DW'(-dy) : DW'(dy);
      orv = orv | mx4[k] | my4[k];
    end
    // shift that brings the largest magnitude of the finger below 2^30
    orw     = 64'(orv);
    sh_calc = orw[32] ? 2'd3 : (orw[31] ? 2'd2 : (orw[30] ? 2'd1 : 2'd0));
    segx    = 64'(mx4[cmd.seg]) >> shamt;
    segy    = 64'(my4[cmd.seg]) >> shamt;

    tdx  = (EW'(px[3]) <<< 2) + EW'(px[3]) - EW'(sum_x);
    tdy  = (EW'(py[3]) <<< 2) + EW'(py[3]) - EW'(sum_y);
    tex  = tdx[EW-1] ? EW'(-tdx) : EW'(tdx);
    tey  = tdy[EW-1] ? EW'(-tdy) : EW'(tdy);
    texw = 64'(tex);
    teyw = 64'(tey);

    opx = cmd.tip ? texw[MW-1:0] : segx[MW-1:0];
    opy = cmd.tip ? teyw[MW-1:0] : segy[MW-1:0];
    opa = (cmd.op == hlsd_pkg::OP_SQ_X) ? opx : opy;

    sr2   = {srem, rad[63:62]};
    trial = 36'({root, 2'b01});
    hyp   = (33'(root) + 33'd1) >> 1;
    dr2   = {drem, dnum[NW-1]};
  end

  assign stat.norm_ok   = (|cx[XW-2:40]) || (|ay_abs[XW-2:40]);
  assign stat.ang_zero  = ang_zero;
  assign stat.path_zero = (path == '0);
  assign stat.tip_big   = (texw >= TIP_LIM) || (teyw >= TIP_LIM);
  assign feat_value     = feat[cmd.eidx];

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      px[cmd.slot] <= rdata[2*CW-1:CW];
      py[cmd.slot] <= rdata[CW-1:0];
    end

    // palm center sum follows the points as they arrive
    if (cmd.wr) begin
      if (cmd.waddr == '0) begin
        sum_x <= SW'(in_beat.point_x);
        sum_y <= SW'(in_beat.point_y);
      end else if (hlsd_pkg::is_knuckle(cmd.waddr)) begin
        sum_x <= sum_x + SW'(in_beat.point_x);
        sum_y <= sum_y + SW'(in_beat.point_y);
      end
    end

    case (cmd.op)
      hlsd_pkg::OP_VEC_LOAD: begin
        if (vx[DW-1]) begin
          cx <= -XW'(vx);
          cy <= -XW'(vy);
          cz <= 32'h8000_0000;
        end else begin
          cx <= XW'(vx);
          cy <= XW'(vy);
          cz <= '0;
        end
      end
      hlsd_pkg::OP_VEC_SHIFT: begin
        if (!stat.norm_ok) begin
          cx <= cx <<< 1;
          cy <= cy <<< 1;
        end
      end
      hlsd_pkg::OP_CORDIC: begin
        if (!cy[XW-1] && (cy != '0)) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + hlsd_pkg::atan_lut(cmd.iter);
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - hlsd_pkg::atan_lut(cmd.iter);
        end
      end
      hlsd_pkg::OP_Z_SAVE: begin
        z1 <= cz;
      end
      hlsd_pkg::OP_ANG_WRITE: begin
        feat[cmd.fidx] <= ang_zero ? '0 : FTW'(arnd);
      end
      hlsd_pkg::OP_STR_INIT: begin
        shamt <= sh_calc;
        path  <= '0;
      end
      hlsd_pkg::OP_SQ_X: begin
        prod <= opa * opa;
      end
      hlsd_pkg::OP_SQ_Y: begin
        sacc <= 64'(prod);
        prod <= opa * opa;
      end
      hlsd_pkg::OP_SQ_ADD: begin
        sacc <= sacc + 64'(prod);
      end
      hlsd_pkg::OP_SQRT_INIT: begin
        rad  <= cmd.tip ? 64'(dnum) : (sacc << 2);
        root <= '0;
        srem <= '0;
      end
      hlsd_pkg::OP_SQRT_STEP: begin
        if (sr2 >= trial) begin
          srem <= 34'(sr2 - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          srem <= 34'(sr2);
          root <= {root[30:0], 1'b0};
        end
        rad <= rad << 2;
      end
      hlsd_pkg::OP_HYP_END: begin
        if (cmd.tip) begin
          feat[cmd.fidx] <= (|hyp[32:FTW]) ? '1 : hyp[FTW-1:0];
        end else if (cmd.seg == 2'd3) begin
          direct <= hyp[31:0];
        end else begin
          path <= path + PW'(hyp);
        end
      end
      hlsd_pkg::OP_DIV_INIT: begin
        drem <= '0;
        if (cmd.tip) begin
          dnum <= NW'(sacc << 2);
          dden <= DNW'(25);
        end else begin
          dnum <= (NW'(direct) << 13) + NW'(path);
          dden <= DNW'(path) << 1;
        end
      end
      hlsd_pkg::OP_DIV_STEP: begin
        if (dr2 >= {1'b0, dden}) begin
          drem <= DNW'(dr2 - {1'b0, dden});
          dnum <= {dnum[NW-2:0], 1'b1};
        end else begin
          drem <= DNW'(dr2);
          dnum <= {dnum[NW-2:0], 1'b0};
        end
      end
      hlsd_pkg::OP_STR_WRITE: begin
        if (path == '0) begin
          feat[cmd.fidx] <= '0;
        end else begin
          feat[cmd.fidx] <= (|dnum[NW-1:FTW]) ? '1 : dnum[FTW-1:0];
        end
      end
      hlsd_pkg::OP_TIP_SAT: begin
        feat[cmd.fidx] <= '1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/hand_landmark_shape_descriptor.sv -----
// ----------------------------------------------------------------------------
// hand_landmark_shape_descriptor
// Gathers the 21 landmarks of a hand and sends its 20 shape features.
// ----------------------------------------------------------------------------
//  channel   handshake                    beat
//  point     point_valid / point_stall    x, y, first_point
//  feature   feature_valid / feature_stall value, index, last_feature
//
// Points are taken one per cycle unless stalled. After the 21st point the
// features are computed by the one-bit-per-cycle normalize shift, the
// 16-step CORDIC, the 32-step square root and the 46-step divider that share
// one datapath. The 20 beats then leave one per cycle unless stalled; points
// of the next hand are taken meanwhile, all but its 21st.
// Reset clears the control only; the landmark memory keeps its contents.
`default_nettype none

module hand_landmark_shape_descriptor (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 point_valid,
  output logic                      point_stall,
  input  wire hlsd_pkg::in_beat_t   point,
  output logic                      feature_valid,
  input  wire logic                 feature_stall,
  output hlsd_pkg::out_beat_t       feature
);

  hlsd_pkg::cmd_t    cmd;
  hlsd_pkg::status_t stat;
  logic [hlsd_pkg::FEAT_W-1:0] feat_value;

  hlsd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (point_valid),
    .first_point (point.first_point),
    .in_stall    (point_stall),
    .out_valid   (feature_valid),
    .out_stall   (feature_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  hlsd_dp u_dp (
    .clk        (clk),
    .in_beat    (point),
    .cmd        (cmd),
    .stat       (stat),
    .feat_value (feat_value)
  );

  assign feature.feature_value = feat_value;
  assign feature.feature_index = cmd.eidx;
  assign feature.last_feature  = (cmd.eidx == hlsd_pkg::FIDX_W'(hlsd_pkg::FEATURES - 1));

endmodule

`default_nettype wire

// ----- sv/hlsd_checker.sv -----
// ----------------------------------------------------------------------------
// hlsd_checker
// Port-level checks of the shape descriptor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsd_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                point_valid,
  input wire logic                point_stall,
  input wire hlsd_pkg::in_beat_t  point,
  input wire logic                feature_valid,
  input wire logic                feature_stall,
  input wire hlsd_pkg::out_beat_t feature
);

  localparam int FW = hlsd_pkg::FIDX_W;

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    feature_valid && feature_stall |=> feature_valid && $stable(feature))
    else $error("stalled feature beat changed");

  // beats of a hand follow in index order without gaps
  a_order: assert property (@(posedge clk) disable iff (rst)
    feature_valid && !feature_stall && !feature.last_feature |=>
      feature_valid && (feature.feature_index == $past(feature.feature_index) + FW'(1)))
    else $error("feature index out of order");

  // last flag marks exactly the final feature
  a_last: assert property (@(posedge clk) disable iff (rst)
    feature_valid |-> (feature.last_feature ==
                       (feature.feature_index == FW'(hlsd_pkg::FEATURES - 1))))
    else $error("last flag mismatch");

  // an angle never exceeds pi
  a_angle: assert property (@(posedge clk) disable iff (rst)
    feature_valid && (feature.feature_index < FW'(hlsd_pkg::STR_BASE)) |->
      (feature.feature_value <= 16'd4096))
    else $error("angle feature above pi");

endmodule

bind hand_landmark_shape_descriptor hlsd_checker u_hlsd_checker (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the hand landmark shape descriptor: hands of 21
// points go in, each set of 20 features is predicted in the bench and checked
// beat by beat, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  // arctangent of 2^-i, 2^32 per turn
  localparam logic [31:0] ARCTAN [16] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
  };

  logic                clk;
  logic                rst;
  logic                point_valid;
  logic                point_stall;
  hlsd_pkg::in_beat_t  point;
  logic                feature_valid;
  logic                feature_stall;
  hlsd_pkg::out_beat_t feature;

  hand_landmark_shape_descriptor u_top (
    .clk           (clk),
    .rst           (rst),
    .point_valid   (point_valid),
    .point_stall   (point_stall),
    .point         (point),
    .feature_valid (feature_valid),
    .feature_stall (feature_stall),
    .feature       (feature)
  );

  // shadow of the hand being gathered
  longint      hand_x [hlsd_pkg::LANDMARKS];
  longint      hand_y [hlsd_pkg::LANDMARKS];
  int unsigned next_landmark;

  hlsd_pkg::out_beat_t pending_features [$];
  int          errors;
  int          points_sent;
  int          hands_done;
  int          features_seen;
  int          gap_pct;
  int          stall_pct;
  int          holdoff_left;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned magnitude(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // rounded length of (ax, ay) / div
  function automatic longint unsigned length_div(input longint unsigned ax,
                                                 input longint unsigned ay,
                                                 input longint unsigned div);
    longint unsigned t;
    t = int_sqrt((4 * (ax * ax + ay * ay)) / (div * div));
    return (t + 1) >> 1;
  endfunction

  function automatic logic [31:0] direction(input longint x, input longint y);
    logic [31:0]     z;
    longint unsigned m;
    longint          xs, ys;
    z = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    m = magnitude(x) > magnitude(y) ? magnitude(x) : magnitude(y);
    while (m < (64'd1 << 40)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + ARCTAN[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ARCTAN[i];
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] bend_angle(input int a, input int b, input int c);
    longint      v1x, v1y, v2x, v2y;
    logic [31:0] d;
    v1x = hand_x[a] - hand_x[b];
    v1y = hand_y[a] - hand_y[b];
    v2x = hand_x[c] - hand_x[b];
    v2y = hand_y[c] - hand_y[b];
    if ((v1x == 0 && v1y == 0) || (v2x == 0 && v2y == 0)) return 16'd0;
    d = direction(v1x, v1y) - direction(v2x, v2y);
    if (d > 32'h8000_0000) d = 32'h0 - d;
    return 16'((longint'(d) + (1 << 18)) >> 19);
  endfunction

  function automatic logic [15:0] straight_ratio(input int base);
    longint unsigned dx [4], dy [4];
    longint unsigned mx, path, direct, q;
    int              s;
    mx = 0;
    path = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      dx[i] = magnitude(hand_x[base+i+1] - hand_x[base+i]);
      dy[i] = magnitude(hand_y[base+i+1] - hand_y[base+i]);
    end
    dx[3] = magnitude(hand_x[base+3] - hand_x[base]);
    dy[3] = magnitude(hand_y[base+3] - hand_y[base]);
    for (int i = 0; i < 4; i++) begin
      if (dx[i] > mx) mx = dx[i];
      if (dy[i] > mx) mx = dy[i];
    end
    while ((mx >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) path += length_div(dx[i] >> s, dy[i] >> s, 1);
    if (path == 0) return 16'd0;
    direct = length_div(dx[3] >> s, dy[3] >> s, 1);
    q = (direct * 8192 + path) / (2 * path);
    return q > 65535 ? 16'hFFFF : 16'(q);
  endfunction

  function automatic logic [15:0] tip_to_palm(input int tip, input longint sx,
                                              input longint sy);
    longint unsigned ex, ey, d;
    ex = magnitude(5 * hand_x[tip] - sx);
    ey = magnitude(5 * hand_y[tip] - sy);
    if (ex >= 5 * 65536 || ey >= 5 * 65536) return 16'hFFFF;
    d = length_div(ex, ey, 5);
    return d > 65535 ? 16'hFFFF : 16'(d);
  endfunction

  // take one accepted point, queue the features of a completed hand
  task automatic take_point(input hlsd_pkg::in_beat_t p);
    logic [15:0]         feat [hlsd_pkg::FEATURES];
    longint              sx, sy;
    hlsd_pkg::out_beat_t beat;
    int unsigned         idx;
    if (p.first_point) next_landmark = 0;
    idx = next_landmark < hlsd_pkg::LANDMARKS ? next_landmark : 0;
    hand_x[idx] = longint'(p.point_x);
    hand_y[idx] = longint'(p.point_y);
    next_landmark = idx + 1;
    if (next_landmark < hlsd_pkg::LANDMARKS) return;
    next_landmark = 0;
    for (int f = 0; f < hlsd_pkg::FINGERS; f++) begin
      feat[2*f]   = bend_angle(1 + 4*f, 2 + 4*f, 3 + 4*f);
      feat[2*f+1] = bend_angle(2 + 4*f, 3 + 4*f, 4 + 4*f);
      feat[hlsd_pkg::STR_BASE+f] = straight_ratio(1 + 4*f);
    end
    sx = hand_x[0];
    sy = hand_y[0];
    for (int f = 0; f < 4; f++) begin
      sx += hand_x[5 + 4*f];
      sy += hand_y[5 + 4*f];
    end
    for (int f = 0; f < hlsd_pkg::FINGERS; f++)
      feat[hlsd_pkg::TIP_BASE+f] = tip_to_palm(4 + 4*f, sx, sy);
    for (int k = 0; k < hlsd_pkg::FEATURES; k++) begin
      beat.feature_value = feat[k];
      beat.feature_index = hlsd_pkg::FIDX_W'(k);
      beat.last_feature  = (k == hlsd_pkg::FEATURES - 1);
      pending_features = {pending_features, beat};
    end
    hands_done++;
  endtask

  // offer one point beat, return once it is accepted
  task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                            input logic first);
    while ($urandom_range(99) < gap_pct) begin
      point_valid = 1'b0;
      @(negedge clk);
    end
    point_valid       = 1'b1;
    point.point_x     = x;
    point.point_y     = y;
    point.first_point = first;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    take_point(point);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    point_valid = 1'b0;
    wait (pending_features.size() == 0);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coord(input logic [15:0] center);
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return center;
      default: return center + 16'($urandom_range(8191)) - 16'd4096;
    endcase
  endfunction

  task automatic send_random_hand();
    logic [15:0] cx, cy;
    cx = 16'($urandom_range(16383)) - 16'd8192;
    cy = 16'($urandom_range(16383)) - 16'd8192;
    for (int i = 0; i < hlsd_pkg::LANDMARKS; i++) begin
      if ($urandom_range(3) == 0) begin
        cx = rand_coord(cx);
        cy = rand_coord(cy);
      end else begin
        cx = cx + 16'($urandom_range(2047)) - 16'd1024;
        cy = cy + 16'($urandom_range(2047)) - 16'd1024;
      end
      send_point(cx, cy, i == 0 ? 1'b1 : 1'($urandom_range(29) == 0));
    end
  endtask

  // no idling on either side here
  task automatic test_directed();
    gap_pct   = 0;
    stall_pct = 0;
    // zero vectors and degenerate fingers: every landmark at one place
    for (int i = 0; i < hlsd_pkg::LANDMARKS; i++) send_point(16'h1234, 16'hF00D, i == 0);
    // far points: alternating corners of the range
    for (int i = 0; i < hlsd_pkg::LANDMARKS; i++)
      send_point(i[0] ? 16'h7FFF : 16'h8000, i[1] ? 16'h8000 : 16'h7FFF, i == 0);
    // partial hand thrown away by a new first point
    for (int i = 0; i < 4; i++) send_point(16'(i * 300), 16'(-i * 200), i == 0);
    for (int i = 0; i < hlsd_pkg::LANDMARKS; i++)
      send_point(16'(i * 512), 16'((i % 4) * 700 - 900), i == 0);
    // point after the 21st with no first mark starts a new hand
    for (int i = 0; i < hlsd_pkg::LANDMARKS; i++)
      send_point(16'(-i * 257), 16'(i * i * 31), 1'b0);
    drain();
  endtask

  task automatic test_random_phase(input int gap, input int stall, input int hands);
    gap_pct   = gap;
    stall_pct = stall;
    for (int h = 0; h < hands; h++) begin
      if ($urandom_range(4) == 0) begin
        // broken hand: a few noise points, then a proper restart
        for (int i = $urandom_range(12); i > 0; i--)
          send_point(16'($urandom), 16'($urandom), 1'($urandom));
      end
      send_random_hand();
    end
    drain();
  endtask

  task automatic test_backpressure();
    gap_pct      = 0;
    stall_pct    = 0;
    holdoff_left = 4000;
    send_random_hand();
    send_random_hand();
    drain();
  endtask

  task automatic test_pause();
    gap_pct   = 20;
    stall_pct = 20;
    send_random_hand();
    drain();
  endtask

  // receiver side stall
  always @(negedge clk) begin
    if (rst) begin
      feature_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      feature_stall <= 1'b1;
      holdoff_left  = holdoff_left - 1;
    end else begin
      feature_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare each feature beat with the oldest prediction
  always @(posedge clk) begin
    hlsd_pkg::out_beat_t want;
    if (!rst && feature_valid && !feature_stall) begin
      features_seen++;
      if (pending_features.size() == 0) begin
        $error("feature beat with no prediction: index %0d", feature.feature_index);
        errors++;
      end else begin
        want = pending_features.pop_front();
        if (feature.feature_value !== want.feature_value) begin
          $error("feature_value (index %0d): expected %0d, got %0d",
                 want.feature_index, want.feature_value, feature.feature_value);
          errors++;
        end
        if (feature.feature_index !== want.feature_index) begin
          $error("feature_index: expected %0d, got %0d",
                 want.feature_index, feature.feature_index);
          errors++;
        end
        if (feature.last_feature !== want.last_feature) begin
          $error("last_feature: expected %0d, got %0d",
                 want.last_feature, feature.last_feature);
          errors++;
        end
      end
    end
  end

  // no beat moving on either channel for too long
  always @(posedge clk) begin
    if (rst || (point_valid && !point_stall) || (feature_valid && !feature_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    point_valid   = 1'b0;
    point         = '0;
    errors        = 0;
    points_sent   = 0;
    hands_done    = 0;
    features_seen = 0;
    gap_pct       = 0;
    stall_pct     = 0;
    holdoff_left  = 0;
    next_landmark = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_phase(63, 0, 1);
    test_random_phase(0, 63, 1);
    test_random_phase(33, 33, 1);
    test_backpressure();
    test_pause();

    drain();
    repeat (200) @(posedge clk);
    if (pending_features.size() != 0) begin
      $error("%0d predicted features never arrived", pending_features.size());
      errors++;
    end
    $display("covered %0d points, %0d hands, %0d feature beats checked",
             points_sent, hands_done, features_seen);
    $display("phases: directed without idling, idle mixes, long receiver hold-off, "
             , "sender pause");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
